>>> rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    // Operation codes carried by one input beat
    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_REAR  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_REAR   = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_REAR  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-chain command, seen from the end that the chain keeps at cell 0
    typedef struct packed {
        logic push_near;  // shift away from cell 0, load cell 0
        logic push_far;   // load the first free cell
        logic pop_near;   // shift towards cell 0
    } t_chain_ctl;

endpackage

>>> rtl/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell #(
    parameter int W     = 8,
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                i_clk,
    input  deq_pkg::t_chain_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    input  logic [W-1:0]        i_push_data,
    input  logic [W-1:0]        i_prev_data,
    input  logic [W-1:0]        i_next_data,
    output logic [W-1:0]        o_data
);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push_near) begin
            n_data = i_prev_data;
        end else if (i_ctl.push_far && (i_count == CNT_W'(IDX))) begin
            n_data = i_push_data;
        end else if (i_ctl.pop_near) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> rtl/deq_chain.sv
`timescale 1ns / 1ps

module deq_chain #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  logic                i_clk,
    input  deq_pkg::t_chain_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    input  logic [W-1:0]        i_push_data,
    output logic [W-1:0]        o_head_data
);

    logic [W-1:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [W-1:0] w_prev;
        logic [W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = i_push_data;
        end else begin : g_mid_prev
            assign w_prev = w_data[g-1];
        end

        // Last cell holds on a shift towards cell 0
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid_next
            assign w_next = w_data[g+1];
        end

        deq_cell #(
            .W     (W),
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_count     (i_count),
            .i_push_data (i_push_data),
            .i_prev_data (w_prev),
            .i_next_data (w_next),
            .o_data      (w_data[g])
        );
    end

    assign o_head_data = w_data[0];

endmodule

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_stall    i_func, i_push_data
// output   out        o_valid / i_stall    o_read_data, o_status, o_fill_count, o_is_empty
//
// One beat per cycle while o_stall is low: each accepted operation updates both cell chains
// and the count at the accepting edge, where its result is also loaded into the output register.
// Reset (i_rst_n low at a clock edge) empties the deque and drops a pending result.
// A stalled output result holds; the input stalls only while that result waits.
// Cell contents are not reset; no cell beyond the fill count is ever read.

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_func,
    input  logic [ELEM_WIDTH-1:0]         i_push_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ELEM_WIDTH-1:0]         o_read_data,
    output logic [1:0]                    o_status,
    output logic [$clog2(DEPTH+1)-1:0]    o_fill_count,
    output logic                          o_is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // The deque is kept twice, in two rows of cells: the front row holds the
    // front element in its cell 0, the rear row holds the rear element in its
    // cell 0. Every operation then reads both ends at fixed cells, and each
    // row only ever shifts by one place or loads the cell at the fill count.

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    deq_pkg::t_chain_ctl       w_ctl_front;
    deq_pkg::t_chain_ctl       w_ctl_rear;
    logic [ELEM_WIDTH-1:0]     w_front_head;
    logic [ELEM_WIDTH-1:0]     w_rear_head;
    logic [ELEM_WIDTH-1:0]     w_read_data;
    deq_pkg::t_status          w_status;

    logic                      r_out_valid;
    logic [ELEM_WIDTH-1:0]     r_read_data;
    logic [1:0]                r_status;
    logic [CNT_W-1:0]          r_fill_count;
    logic                      r_is_empty;

    // Hold the input only while a result waits in the output register
    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // Decode the operation into row commands, result and next count
    always_comb begin
        w_ctl_front = '0;
        w_ctl_rear  = '0;
        w_read_data = '0;
        w_status    = deq_pkg::ST_OK;
        n_count     = r_count;
        unique case (deq_pkg::t_func'(i_func)) inside
            deq_pkg::FN_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = deq_pkg::ST_FULL;
                end else begin
                    w_ctl_front.push_near = w_accept;
                    w_ctl_rear.push_far   = w_accept;
                    n_count               = r_count + 1'b1;
                end
            end
            deq_pkg::FN_PUSH_REAR: begin
                if (w_full) begin
                    w_status = deq_pkg::ST_FULL;
                end else begin
                    w_ctl_front.push_far = w_accept;
                    w_ctl_rear.push_near = w_accept;
                    n_count              = r_count + 1'b1;
                end
            end
            deq_pkg::FN_POP_FRONT, deq_pkg::FN_PEEK_FRONT: begin
                if (w_empty) begin
                    w_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_read_data = w_front_head;
                    if (deq_pkg::t_func'(i_func) == deq_pkg::FN_POP_FRONT) begin
                        // Front row drops its head; rear row loses its last
                        // element through the count alone
                        w_ctl_front.pop_near = w_accept;
                        n_count              = r_count - 1'b1;
                    end
                end
            end
            deq_pkg::FN_POP_REAR, deq_pkg::FN_PEEK_REAR: begin
                if (w_empty) begin
                    w_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_read_data = w_rear_head;
                    if (deq_pkg::t_func'(i_func) == deq_pkg::FN_POP_REAR) begin
                        w_ctl_rear.pop_near = w_accept;
                        n_count             = r_count - 1'b1;
                    end
                end
            end
            default: begin
                // Unused codes: no operation, plain ok result
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    deq_chain #(
        .W     (ELEM_WIDTH),
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_front_row (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl_front),
        .i_count     (r_count),
        .i_push_data (i_push_data),
        .o_head_data (w_front_head)
    );

    deq_chain #(
        .W     (ELEM_WIDTH),
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_rear_row (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl_rear),
        .i_count     (r_count),
        .i_push_data (i_push_data),
        .o_head_data (w_rear_head)
    );

    // Output register: load on every accepted beat, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_data  <= w_read_data;
            r_status     <= w_status;
            r_fill_count <= n_count;
            r_is_empty   <= (n_count == '0);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_status     = r_status;
    assign o_fill_count = r_fill_count;
    assign o_is_empty   = r_is_empty;

    // Count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above capacity");

    // With one element held, both rows show the same head
    a_single_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(1)) |-> (w_front_head == w_rear_head))
        else $error("front and rear rows disagree on a single element");

    // A push into a full deque is refused and leaves the count at capacity
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (i_func == deq_pkg::FN_PUSH_FRONT
                                || i_func == deq_pkg::FN_PUSH_REAR))
        |=> (o_status == deq_pkg::ST_FULL) && (o_fill_count == CNT_W'(DEPTH))
            && (r_count == CNT_W'(DEPTH)))
        else $error("push into full deque not dropped");

    // A pop from a non-empty deque takes exactly one element
    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_empty && (i_func == deq_pkg::FN_POP_FRONT
                                  || i_func == deq_pkg::FN_POP_REAR))
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not remove one element");

    // Empty flag agrees with the reported count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_fill_count == '0)))
        else $error("empty flag disagrees with fill count");

endmodule
